>>> hw/rtl/vlm_pkg.sv
// Package for the vibration level meter: field widths, constants, register
// indexes and the sequencer state type. No dependencies.
package vlm_pkg;

    localparam int ACCEL_W  = 16;
    localparam int LEVEL_W  = 24;
    localparam int ALPHA_W  = 9;
    localparam int GAIN_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam int NUM_W    = 26;   // weighted sum of sample and previous sample
    localparam int DEV_W    = 17;   // deviation from the low-pass value
    localparam int SUMSQ_W  = 34;   // sum of three squared deviations
    localparam int RAD_W    = 50;   // sum of squares shifted up by 16
    localparam int ROOT_W   = 25;
    localparam int CNT_W    = 5;
    localparam int MUL_W    = 31;
    localparam int PROD_W   = 62;
    localparam int G10K_W   = 22;   // gain times 10000
    localparam int SCALE_SHIFT = 22;
    localparam int RAW_LVL_W = 26;

    localparam int WINDOW_DEF = 5;

    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 9'd128;
    localparam logic [ALPHA_W-1:0]  ALPHA_FULL  = 9'd256;
    localparam logic [GAIN_W-1:0]   GAIN_RESET  = 8'd10;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 24'd8900000;
    localparam logic [MUL_W-1:0]    LEVEL_SCALE = 31'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MA,
        S_MP,
        S_DEV,
        S_SQ,
        S_ACC,
        S_ROOT_GO,
        S_ROOT,
        S_LM,
        S_LVL,
        S_DIV,
        S_Q
    } t_state;

endpackage

>>> hw/rtl/vlm_in_if.sv
// Input channel of the vibration level meter: one three-axis sample per request.
// Depends on vlm_pkg.
interface vlm_in_if;
    import vlm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ACCEL_W-1:0]  accel_x;
    logic signed [ACCEL_W-1:0]  accel_y;
    logic signed [ACCEL_W-1:0]  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

>>> hw/rtl/vlm_out_if.sv
// Output channel of the vibration level meter: instantaneous and averaged level.
// Depends on vlm_pkg.
interface vlm_out_if;
    import vlm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LEVEL_W-1:0]     level_now;
    logic [LEVEL_W-1:0]     level_smoothed;

    modport source (output valid, output level_now, output level_smoothed,
                    input ready);
    modport sink   (input valid, input level_now, input level_smoothed,
                    output ready);
endinterface

>>> hw/rtl/vlm_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on vlm_pkg.
module vlm_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vlm_pkg::RAD_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [vlm_pkg::ROOT_W-1:0]  o_root
);
    import vlm_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                fits;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> hw/rtl/vibration_level_meter.sv
// Vibration level meter. The first sample after reset only loads the previous
// sample registers and gives no result. Every later sample holds ready low until
// its result is loaded into the output registers, so no new sample is taken while
// one is in progress. Per axis the shared multiplier forms the low-pass products
// and the squared deviation; then come the square root, gain scaling and mean. A
// waiting result stalls the next sample only when that sample has finished.
// Synchronous active-low reset clears the window, running sum and control registers.
module vibration_level_meter #(
    parameter int WINDOW = vlm_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vlm_in_if.sink                          i_in,
    vlm_out_if.source                       o_out
);
    import vlm_pkg::*;

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = LEVEL_W + $clog2(WINDOW);
    localparam logic [TOTAL_W:0] RECIP = (TOTAL_W + 1)'((64'd1 << TOTAL_W) / WINDOW);

    t_state                     r_state;
    t_state                     n_state;

    logic [ALPHA_W-1:0]         r_alpha;
    logic [GAIN_W-1:0]          r_gain;
    logic                       r_primed;
    logic signed [ACCEL_W-1:0]  r_a    [3];
    logic signed [ACCEL_W-1:0]  r_prev [3];
    logic [1:0]                 r_k;
    logic signed [NUM_W-1:0]    r_num;
    logic signed [DEV_W-1:0]    r_d;
    logic [SUMSQ_W-1:0]         r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic [LEVEL_W-1:0]         r_win  [WINDOW];
    logic [SLOT_W-1:0]          r_slot;
    logic [TOTAL_W-1:0]         r_total;
    logic [LEVEL_W-1:0]         r_level;
    logic                       r_out_valid;
    logic [LEVEL_W-1:0]         r_out_now;
    logic [LEVEL_W-1:0]         r_out_smooth;

    logic                       in_ready;
    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic                       sqrt_start;
    logic                       out_load;

    logic                       sqrt_done;
    logic [ROOT_W-1:0]          root;

    logic [ALPHA_W-1:0]         alpha_sat;
    logic signed [ACCEL_W-1:0]  cur_a;
    logic signed [ACCEL_W-1:0]  cur_p;
    logic signed [NUM_W-1:0]    num;
    logic signed [NUM_W-1:0]    num_adj;
    logic signed [NUM_W-1:0]    filt;
    logic signed [NUM_W-1:0]    dev_full;
    logic [RAW_LVL_W-1:0]       lvl_raw;
    logic [LEVEL_W-1:0]         lvl_sat;
    logic [LEVEL_W-1:0]         q0;
    logic [TOTAL_W-1:0]         q0_w;
    logic [TOTAL_W-1:0]         rem;
    logic [LEVEL_W-1:0]         smooth;
    logic                       in_take;
    logic                       out_take;

    vlm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({r_sum, 16'd0}),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    assign in_take  = i_in.valid && in_ready;
    assign out_take = r_out_valid && o_out.ready;

    always_comb begin
        alpha_sat = (r_alpha > ALPHA_FULL) ? ALPHA_FULL : r_alpha;
        cur_a     = r_a[r_k];
        cur_p     = r_prev[r_k];

        // Division by 256 truncates toward zero, so negative sums are biased up.
        num       = r_num + $signed(r_prod[NUM_W-1:0]);
        num_adj   = num[NUM_W-1] ? (num + NUM_W'(255)) : num;
        filt      = num_adj >>> 8;
        dev_full  = NUM_W'(cur_a) - filt;

        lvl_raw   = r_prod[SCALE_SHIFT +: RAW_LVL_W];
        lvl_sat   = (lvl_raw > RAW_LVL_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl_raw[LEVEL_W-1:0];

        // The reciprocal estimate is either exact or one below the true mean.
        q0        = r_prod[TOTAL_W +: LEVEL_W];
        q0_w      = TOTAL_W'(q0) * TOTAL_W'(WINDOW);
        rem       = r_total - q0_w;
        smooth    = (rem >= TOTAL_W'(WINDOW)) ? (q0 + 1'b1) : q0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take && r_primed) begin
                    n_state = S_MA;
                end
            end
            S_MA:      n_state = S_MP;
            S_MP:      n_state = S_DEV;
            S_DEV:     n_state = S_SQ;
            S_SQ:      n_state = S_ACC;
            S_ACC: begin
                n_state = (r_k == 2'd2) ? S_ROOT_GO : S_MA;
            end
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT: begin
                if (sqrt_done) begin
                    n_state = S_LM;
                end
            end
            S_LM:      n_state = S_LVL;
            S_LVL:     n_state = S_DIV;
            S_DIV:     n_state = S_Q;
            S_Q: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and unit controls
    always_comb begin
        in_ready   = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_MA: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(alpha_sat));
                mul_b  = MUL_W'(cur_a);
            end
            S_MP: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(ALPHA_FULL - alpha_sat));
                mul_b  = MUL_W'(cur_p);
            end
            S_DEV: begin
            end
            S_SQ: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_d);
                mul_b  = MUL_W'(r_d);
            end
            S_ACC: begin
            end
            S_ROOT_GO: begin
                sqrt_start = 1'b1;
                mul_en     = 1'b1;
                mul_a      = $signed(MUL_W'(r_gain));
                mul_b      = $signed(LEVEL_SCALE);
            end
            S_ROOT: begin
            end
            S_LM: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(root));
                mul_b  = $signed(MUL_W'(r_prod[G10K_W-1:0]));
            end
            S_LVL: begin
            end
            S_DIV: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(r_total));
                mul_b  = $signed(MUL_W'(RECIP));
            end
            S_Q: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= ALPHA_RESET;
            r_gain      <= GAIN_RESET;
            r_primed    <= 1'b0;
            r_slot      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
            end
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_take && !r_primed) begin
                r_primed  <= 1'b1;
                r_prev[0] <= i_in.accel_x;
                r_prev[1] <= i_in.accel_y;
                r_prev[2] <= i_in.accel_z;
            end

            if (in_take) begin
                r_k <= '0;
            end else if (r_state == S_ACC) begin
                r_k <= r_k + 1'b1;
            end

            if (r_state == S_LVL) begin
                r_prev[0]     <= r_a[0];
                r_prev[1]     <= r_a[1];
                r_prev[2]     <= r_a[2];
                r_win[r_slot] <= lvl_sat;
                r_total       <= r_total - TOTAL_W'(r_win[r_slot]) + TOTAL_W'(lvl_sat);
                r_slot        <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a[0] <= i_in.accel_x;
            r_a[1] <= i_in.accel_y;
            r_a[2] <= i_in.accel_z;
            r_sum  <= '0;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_MP) begin
            r_num <= $signed(r_prod[NUM_W-1:0]);
        end
        if (r_state == S_DEV) begin
            r_d <= dev_full[DEV_W-1:0];
        end
        if (r_state == S_ACC) begin
            r_sum <= r_sum + r_prod[SUMSQ_W-1:0];
        end
        if (r_state == S_LVL) begin
            r_level <= lvl_sat;
        end
        if (out_load) begin
            r_out_now    <= r_level;
            r_out_smooth <= smooth;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.level_now      = r_out_now;
    assign o_out.level_smoothed = r_out_smooth;

endmodule
